@@ hw/rtl/assert_macros.svh @@
// assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ hw/rtl/lpcs_pkg.sv @@
package lpcs_pkg;

  localparam int MAX_LEN_DEFAULT = 1024;
  localparam int START_W = 10;
  localparam int LENGTH_W = 11;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOADR,
    ST_SCAN,
    ST_FIN,
    ST_OUT
  } lpcs_state_t;

endpackage

@@ hw/rtl/longest_palindrome_column_scan.sv @@
// bytes load one per cycle while busy is low; a transaction without last leaves the block idle
// after the last byte of a string the scan makes one text memory read per scanned span,
// plus one per column, and then gives the result strobe
// busy rises once the last byte is taken and stays high through the result cycle; the result is not held
// rst (synchronous) empties the string and clears the flags; no memory clearing pass
module longest_palindrome_column_scan #(
  parameter int MAX_LEN = lpcs_pkg::MAX_LEN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     ch,
  input  logic                           last,
  output logic                           done,
  output logic [lpcs_pkg::START_W-1:0]   start_res,
  output logic [lpcs_pkg::LENGTH_W-1:0]  length,
  output logic                           overflow
);
  import lpcs_pkg::*;

  `include "assert_macros.svh"

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int BW = (CW > LENGTH_W) ? CW : LENGTH_W;

  lpcs_state_t state, state_next;

  logic [CW-1:0] count;
  logic          overflow_flag;
  logic [AW-1:0] r;
  logic [AW-1:0] l;
  logic [7:0]    cr;
  logic          cr_pend;
  logic          p_v;
  logic [AW-1:0] p_l;
  logic [BW-1:0] p_span;
  logic          p_bank;
  logic [BW-1:0] best_start;
  logic [BW-1:0] best_len;

  logic          accept;
  logic          store;
  logic          col_end;
  logic          str_end;
  logic [AW-1:0] txt_raddr;
  logic [7:0]    txt_rdata;
  logic [AW:0]   col_raddr;
  logic [AW:0]   col_waddr;
  logic          col_rdata;
  logic          pal;
  logic [BW-1:0] span;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign store   = accept && (count < CW'(MAX_LEN));
  assign col_end = (l == r);
  assign str_end = col_end && (CW'(r) == count - CW'(1));
  assign span    = BW'(r) - BW'(l) + BW'(1);

  assign txt_raddr = (state == ST_LOADR) ? r : l;
  assign col_raddr = {~r[0], l + AW'(1)};
  assign col_waddr = {p_bank, p_l};

  // span is a palindrome when its ends match and it is at most three long or the inner span was one
  assign pal = (txt_rdata == cr) && ((p_span <= BW'(3)) || col_rdata);

  lpcs_ram #(.DW(8), .AW(AW)) u_text (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (ch),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  // two banks of column bits, selected by parity of the end index
  lpcs_ram #(.DW(1), .AW(AW + 1)) u_col (
    .clk   (clk),
    .we    (p_v),
    .waddr (col_waddr),
    .wdata (pal),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && last) begin
          state_next = ST_LOADR;
        end
      end
      ST_LOADR: begin
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (str_end) begin
          state_next = ST_FIN;
        end else if (col_end) begin
          state_next = ST_LOADR;
        end
      end
      ST_FIN: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_flag <= 1'b0;
      best_start    <= '0;
      best_len      <= '0;
      p_v           <= 1'b0;
      cr_pend       <= 1'b0;
      r             <= '0;
      l             <= '0;
    end else begin
      cr_pend <= (state == ST_LOADR);
      p_v     <= (state == ST_SCAN);
      if (accept) begin
        if (store) begin
          count <= count + CW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
        if (last) begin
          r          <= '0;
          best_start <= '0;
          best_len   <= BW'(1);
        end
      end
      if (state == ST_LOADR) begin
        l <= '0;
      end
      if (state == ST_SCAN) begin
        l <= l + AW'(1);
        if (col_end && !str_end) begin
          r <= r + AW'(1);
        end
      end
      if (p_v && pal && (p_span > best_len)) begin
        best_len   <= p_span;
        best_start <= BW'(p_l);
      end
      if (state == ST_OUT) begin
        count         <= '0;
        overflow_flag <= 1'b0;
        best_start    <= '0;
        best_len      <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cr_pend) begin
      cr <= txt_rdata;
    end
    p_l    <= l;
    p_span <= span;
    p_bank <= r[0];
  end

  assign start_res = best_start[START_W-1:0];
  assign length    = best_len[LENGTH_W-1:0];
  assign overflow  = overflow_flag;

  `ASSERT_IMPLIES(a_scan_order, clk, rst, state == ST_SCAN, l <= r, "start index past end index")
  `ASSERT_IMPLIES(a_best_fits, clk, rst, busy, best_len <= BW'(count), "best span longer than string")
  `ASSERT_IMPLIES(a_best_set, clk, rst, done, best_len != '0, "result with zero length")
  `ASSERT_NEXT(a_done_idle, clk, rst, done, !busy && count == '0, "block not emptied after result")
  `ASSERT_IMPLIES(a_pipe_scan, clk, rst, p_v, state == ST_SCAN || state == ST_LOADR || state == ST_FIN, "span compare outside scan")

endmodule

@@ hw/rtl/lpcs_ram.sv @@
module lpcs_ram #(
  parameter int DW = 8,
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ dv/longest_palindrome_column_scan_tb.sv @@
`timescale 1ns / 100ps

module longest_palindrome_column_scan_tb;

  import lpcs_pkg::*;

  localparam int TEXT_DEPTH = MAX_LEN_DEFAULT;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 20;

  typedef logic [7:0] text_q_t[$];

  typedef struct {
    logic [START_W-1:0]  start_pos;
    logic [LENGTH_W-1:0] span_len;
    logic                dropped;
  } palindrome_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [7:0]          ch = 8'h00;
  logic                last = 1'b0;
  logic                busy;
  logic                done;
  logic [START_W-1:0]  start_res;
  logic [LENGTH_W-1:0] length;
  logic                overflow;

  palindrome_t expected_palindromes[$];
  text_q_t     held_text;
  logic        held_dropped = 1'b0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          items_sent = 0;
  bit          idle_enable = 1'b1;

  longest_palindrome_column_scan u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .ch        (ch),
    .last      (last),
    .done      (done),
    .start_res (start_res),
    .length    (length),
    .overflow  (overflow)
  );

  always #2 clk = ~clk;

  function automatic palindrome_t predict_longest(input text_q_t txt, input logic dropped);
    bit          prev_col[TEXT_DEPTH];
    bit          cur_col[TEXT_DEPTH];
    int          n;
    int          span;
    int          best_s;
    int          best_l;
    bit          pal;
    palindrome_t res;
    n = txt.size();
    best_s = 0;
    best_l = (n > 0) ? 1 : 0;
    for (int r = 0; r < n; r++) begin
      for (int l = 0; l <= r; l++) begin
        span = r - l + 1;
        pal = 1'b0;
        if (txt[l] == txt[r]) begin
          pal = (span <= 3) ? 1'b1 : prev_col[l+1];
        end
        cur_col[l] = pal;
        if (pal && span > best_l) begin
          best_l = span;
          best_s = l;
        end
      end
      prev_col = cur_col;
    end
    res.start_pos = best_s[START_W-1:0];
    res.span_len  = best_l[LENGTH_W-1:0];
    res.dropped   = dropped;
    return res;
  endfunction

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // start stays high from one transaction to the next unless a gap is inserted
  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (idle_enable && $urandom_range(99) < 29) idle_cycles($urandom_range(6, 1));
    start <= 1'b1;
    ch    <= b;
    last  <= lst;
    do @(posedge clk); while (busy);
    items_sent++;
    if (held_text.size() < TEXT_DEPTH) held_text.push_back(b);
    else held_dropped = 1'b1;
    if (lst) begin
      expected_palindromes.push_back(predict_longest(held_text, held_dropped));
      held_text.delete();
      held_dropped = 1'b0;
    end
  endtask

  task automatic send_string(input text_q_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
  endtask

  task automatic test_single_byte();
    send_string('{8'h00});
    send_string('{8'hff});
  endtask

  task automatic test_short_spans();
    send_string('{8'h00, 8'h00});
    send_string('{8'h12, 8'h34});
    send_string('{8'h61, 8'h62, 8'h61});
    send_string('{8'h61, 8'h62, 8'h62, 8'h61});
  endtask

  // equal lengths: the span ending first must win
  task automatic test_equal_length_ties();
    send_string('{8'h61, 8'h62, 8'h61, 8'h63, 8'h64, 8'h63});
    send_string('{8'h78, 8'h61, 8'h61, 8'h79, 8'h62, 8'h62});
  endtask

  // full buffer of a long run, then dropped bytes, the final one carrying the last flag
  task automatic test_overflow();
    text_q_t s;
    s.push_back(8'h01);
    repeat (TEXT_DEPTH - 1) s.push_back(8'h5a);
    repeat (6) s.push_back(8'($urandom_range(255)));
    send_string(s);
  endtask

  task automatic test_random_strings();
    text_q_t s;
    int      n;
    int      pick;
    int      mode;
    int      alpha;
    int      centre;
    logic [7:0] base;
    while (items_sent < RANDOM_ITEMS + 1100) begin
      pick = $urandom_range(99);
      if (pick < 85) n = $urandom_range(12, 1);
      else if (pick < 97) n = $urandom_range(40, 13);
      else n = $urandom_range(80, 41);
      mode  = $urandom_range(2);
      alpha = $urandom_range(4, 2);
      base  = 8'($urandom_range(255));
      s.delete();
      for (int i = 0; i < n; i++) begin
        if (mode == 1) s.push_back(base + 8'($urandom_range(alpha - 1)));
        else s.push_back(8'($urandom_range(255)));
      end
      // mirror around a random centre to plant a long palindrome
      if (mode == 2 && n >= 3) begin
        centre = $urandom_range(n - 1);
        for (int k = 1; centre - k >= 0 && centre + k < n; k++) s[centre+k] = s[centre-k];
      end
      idle_enable = !(items_sent > 1400 && items_sent < 1600);
      send_string(s);
    end
    idle_enable = 1'b1;
  endtask

  always @(posedge clk) begin
    palindrome_t exp_res;
    if (!rst && done === 1'b1) begin
      if (expected_palindromes.size() == 0) begin
        $display("%0t: unexpected result start %0d length %0d overflow %0d",
                 $time, start_res, length, overflow);
        mismatch_count++;
      end else begin
        exp_res = expected_palindromes.pop_front();
        if (start_res !== exp_res.start_pos) begin
          $display("%0t: start_res expected %0d actual %0d", $time, exp_res.start_pos, start_res);
          mismatch_count++;
        end
        if (length !== exp_res.span_len) begin
          $display("%0t: length expected %0d actual %0d", $time, exp_res.span_len, length);
          mismatch_count++;
        end
        if (overflow !== exp_res.dropped) begin
          $display("%0t: overflow expected %0d actual %0d", $time, exp_res.dropped, overflow);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_palindromes.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_single_byte();
    test_short_spans();
    test_equal_length_ties();
    test_overflow();
    test_random_strings();
    start <= 1'b0;
    while (expected_palindromes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
